### hdl/swing_bezier_trajectory_eval_assert.svh
// Assertion helpers for the RTL.
`ifndef SWING_BEZIER_TRAJECTORY_EVAL_ASSERT_SVH
`define SWING_BEZIER_TRAJECTORY_EVAL_ASSERT_SVH

// same-cycle implication
`define SBTE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication
`define SBTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

### hdl/sbte_pkg.sv
`default_nettype none

package sbte_pkg;

   localparam int PHASE_W = 18;
   localparam int EASE_W  = 17;
   localparam int COORD_W = 32;
   localparam int WGT_N   = 7;   // b0 b1 b2 b3 c0 c1 c2

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type p0;
      coord_type p3;
      coord_type m0;
      coord_type m1;
   } axis_in_type;

   typedef struct packed {
      coord_type pos;
      coord_type vel;
   } axis_out_type;

endpackage

`default_nettype wire

### hdl/swing_bezier_trajectory_eval.sv
// Swing trajectory evaluator. Each request carries a phase and the two
// endpoints and tangents of a planar cubic curve; the response gives the
// point and its phase derivative, Q16.16 saturated. Phase is clamped to
// 0..1 and time-warped by smoothstep under ease_factor (written on the csr_
// port, values above 1.0 act as 1.0; write only while no request is in
// flight). Throughput is one request per clock unless the response side
// stalls. One shared warp pipeline feeds the basis weights to an x lane
// and a y lane, each with its multiply-accumulate, velocity multiplier and
// saturation stages. When rsp_ready is low the pipeline keeps filling
// until its last stage holds a result, then req_ready drops.
`default_nettype none

`include "swing_bezier_trajectory_eval_assert.svh"

module swing_bezier_trajectory_eval import sbte_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic        [EASE_W-1:0]    csr_ease_factor,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [PHASE_W-1:0]   req_phase,
   input  coord_type                   req_start_x,
   input  coord_type                   req_start_y,
   input  coord_type                   req_end_x,
   input  coord_type                   req_end_y,
   input  coord_type                   req_start_tangent_x,
   input  coord_type                   req_start_tangent_y,
   input  coord_type                   req_end_tangent_x,
   input  coord_type                   req_end_tangent_y,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output coord_type                   rsp_pos_x,
   output coord_type                   rsp_pos_y,
   output coord_type                   rsp_vel_x,
   output coord_type                   rsp_vel_y
);

   localparam int NST = 10;
   localparam int WT  = FRAC_BITS + 1;
   localparam logic [WT-1:0] ONE_W = WT'(1) << FRAC_BITS;
   localparam logic [31:0]   ONE32 = 32'(1) << FRAC_BITS;

   logic [WT-1:0]  k_in, k_ff;
   logic [NST-1:0] vld_in, vld_ff;
   logic           adv, accept, take;

   axis_in_type    pt_x, pt_y;
   axis_out_type   res_x, res_y;
   logic [WT-1:0]  wgt [WGT_N];
   logic [WT-1:0]  du;

   // ease register, clamped to 1.0 on write
   assign csr_ready = !reset;
   assign k_in = (32'(csr_ease_factor) > ONE32) ? ONE_W : WT'(csr_ease_factor);

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         k_ff <= k_in;
      end
   end

   assign adv       = !vld_ff[NST-1] || take;
   assign req_ready = adv && !reset;
   assign accept    = req_valid && req_ready;
   assign vld_in    = {vld_ff[NST-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   assign pt_x.p0 = req_start_x;
   assign pt_x.p3 = req_end_x;
   assign pt_x.m0 = req_start_tangent_x;
   assign pt_x.m1 = req_end_tangent_x;
   assign pt_y.p0 = req_start_y;
   assign pt_y.p3 = req_end_y;
   assign pt_y.m0 = req_start_tangent_y;
   assign pt_y.m1 = req_end_tangent_y;

   sbte_warp #(.FRAC_BITS(FRAC_BITS)) u_warp (
      .clock (clock),
      .adv   (adv),
      .phase (req_phase),
      .ease  (k_ff),
      .wgt   (wgt),
      .du    (du)
   );

   sbte_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
      .clock (clock),
      .adv   (adv),
      .pt    (pt_x),
      .wgt   (wgt),
      .du    (du),
      .res   (res_x)
   );

   sbte_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
      .clock (clock),
      .adv   (adv),
      .pt    (pt_y),
      .wgt   (wgt),
      .du    (du),
      .res   (res_y)
   );

   sbte_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (vld_ff[NST-1]),
      .res_x     (res_x),
      .res_y     (res_y),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_pos_x (rsp_pos_x),
      .rsp_pos_y (rsp_pos_y),
      .rsp_vel_x (rsp_vel_x),
      .rsp_vel_y (rsp_vel_y)
   );

   `SBTE_ASSERT_NEXT(a_accept_enters, clock, reset, accept, vld_ff[0])
   `SBTE_ASSERT_NEXT(a_last_reaches_rsp, clock, reset, vld_ff[NST-1] && take, rsp_valid)
   `SBTE_ASSERT_NEXT(a_stall_holds_pipe, clock, reset, !adv, $stable(vld_ff))
   `SBTE_ASSERT_IMPL(a_ease_clamped, clock, reset, 1'b1, k_ff <= ONE_W)

endmodule

`default_nettype wire

### hdl/sbte_warp.sv
`default_nettype none

module sbte_warp import sbte_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        adv,
   input  logic signed [PHASE_W-1:0]   phase,
   input  logic        [FRAC_BITS:0]   ease,
   output logic        [FRAC_BITS:0]   wgt [WGT_N],
   output logic        [FRAC_BITS:0]   du
);

   localparam int WT = FRAC_BITS + 1;
   localparam int WP = 2 * WT;
   localparam int WR = WP + 4;
   localparam logic [WT-1:0] ONE_W     = WT'(1) << FRAC_BITS;
   localparam logic [31:0]   ONE32     = 32'(1) << FRAC_BITS;
   localparam logic [WT:0]   THREE_ONE = (WT+1)'(3) << FRAC_BITS;
   localparam logic [WR-1:0] HALF_R    = WR'(1) << (FRAC_BITS - 1);

   function automatic logic [WT-1:0] rndu(input logic [WR-1:0] v);
      logic [WR-1:0] a;
      a = v + HALF_R;
      return WT'(a >> FRAC_BITS);
   endfunction

   logic [31:0]   ph_mag;
   logic [WT-1:0] one_k;

   logic [WT-1:0] t0_in, t0_ff;

   logic [WP-1:0] p_tt, p_tomt, p_lin;
   logic [WT-1:0] t2_in, t2_ff;
   logic [WP-1:0] tomt_ff, lin1_ff;
   logic [WT:0]   a3_in, a3_ff;

   logic [WR-1:0] p_s, p_ds6;
   logic [WT-1:0] s_in, s_ff, ds_in, ds_ff;
   logic [WP-1:0] lin2_ff;

   logic [WR-1:0] p_ks, p_u, p_kds, p_du;
   logic [WT-1:0] u3_in, u3_ff, du3_in, du3_ff;

   logic [WT-1:0] om_in, om_ff, u4_ff, du4_ff;
   logic [WP-1:0] p_oo, p_uu, p_ou;
   logic [WT-1:0] om2_in, om2_ff, u2_in, u2_ff, c1_in, c1_ff;

   logic [WP-1:0] p_b0, p_b1, p_b2, p_b3;
   logic [WT-1:0] wgt_in [WGT_N];
   logic [WT-1:0] wgt_ff [WGT_N];
   logic [WT-1:0] du5_ff;

   assign one_k = ONE_W - ease;

   always_comb begin
      ph_mag = 32'(phase[PHASE_W-2:0]);
      if (phase[PHASE_W-1]) begin
         t0_in = '0;
      end else if (ph_mag > ONE32) begin
         t0_in = ONE_W;
      end else begin
         t0_in = WT'(ph_mag);
      end
   end

   assign p_tt   = t0_ff * t0_ff;
   assign p_tomt = t0_ff * (ONE_W - t0_ff);
   assign p_lin  = one_k * t0_ff;
   assign t2_in  = rndu(WR'(p_tt));
   assign a3_in  = THREE_ONE - {t0_ff, 1'b0};

   assign p_s    = t2_ff * a3_ff;
   assign p_ds6  = (WR'(tomt_ff) << 2) + (WR'(tomt_ff) << 1);
   assign s_in   = rndu(p_s);
   assign ds_in  = rndu(p_ds6);

   assign p_ks   = ease * s_ff;
   assign p_u    = p_ks + WR'(lin2_ff);
   assign p_kds  = ease * ds_ff;
   assign p_du   = (WR'(one_k) << FRAC_BITS) + p_kds;
   assign u3_in  = rndu(p_u);
   assign du3_in = rndu(p_du);

   assign om_in  = ONE_W - u3_ff;
   assign p_oo   = om_in * om_in;
   assign p_uu   = u3_ff * u3_ff;
   assign p_ou   = om_in * u3_ff;
   assign om2_in = rndu(WR'(p_oo));
   assign u2_in  = rndu(WR'(p_uu));
   assign c1_in  = rndu(WR'({p_ou, 1'b0}));

   assign p_b0 = om2_ff * om_ff;
   assign p_b1 = om2_ff * u4_ff;
   assign p_b2 = om_ff * u2_ff;
   assign p_b3 = u2_ff * u4_ff;

   assign wgt_in[0] = rndu(WR'(p_b0));
   assign wgt_in[1] = rndu(WR'(p_b1));
   assign wgt_in[2] = rndu(WR'(p_b2));
   assign wgt_in[3] = rndu(WR'(p_b3));
   assign wgt_in[4] = om2_ff;
   assign wgt_in[5] = c1_ff;
   assign wgt_in[6] = u2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         t0_ff   <= t0_in;
         t2_ff   <= t2_in;
         tomt_ff <= p_tomt;
         lin1_ff <= p_lin;
         a3_ff   <= a3_in;
         s_ff    <= s_in;
         ds_ff   <= ds_in;
         lin2_ff <= lin1_ff;
         u3_ff   <= u3_in;
         du3_ff  <= du3_in;
         om_ff   <= om_in;
         u4_ff   <= u3_ff;
         om2_ff  <= om2_in;
         u2_ff   <= u2_in;
         c1_ff   <= c1_in;
         du4_ff  <= du3_ff;
         wgt_ff  <= wgt_in;
         du5_ff  <= du4_ff;
      end
   end

   assign wgt = wgt_ff;
   assign du  = du5_ff;

endmodule

`default_nettype wire

### hdl/sbte_lane.sv
`default_nettype none

module sbte_lane import sbte_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 adv,
   input  axis_in_type          pt,
   input  logic [FRAC_BITS:0]   wgt [WGT_N],
   input  logic [FRAC_BITS:0]   du,
   output axis_out_type         res
);

   localparam int WT  = FRAC_BITS + 1;
   localparam int WQ  = COORD_W + 4;
   localparam int WM  = WQ + WT + 1;
   localparam int WS  = WM + 2;
   localparam int WR  = WS - FRAC_BITS;
   localparam int WV  = WR + WT + 1;
   localparam int WX  = WV - FRAC_BITS;
   localparam int OPD = 5;
   localparam logic signed [WS-1:0] HALF_S = WS'(1) << (FRAC_BITS - 1);
   localparam logic signed [WV-1:0] HALF_V = WV'(1) << (FRAC_BITS - 1);
   localparam logic signed [WX-1:0] MAXV   =
      {{(WX-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
   localparam logic signed [WX-1:0] MINV   =
      {{(WX-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

   function automatic logic signed [WQ-1:0] sx(input coord_type v);
      return {{(WQ-COORD_W){v[COORD_W-1]}}, v};
   endfunction

   function automatic coord_type sat(input logic signed [WX-1:0] v);
      coord_type r;
      if (v > MAXV) begin
         r = {1'b0, {(COORD_W-1){1'b1}}};
      end else if (v < MINV) begin
         r = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

   axis_in_type pt_ff;

   logic signed [WQ-1:0] p0, p3, m0, m1, dd;
   logic signed [WQ-1:0] op_in [WGT_N];
   logic signed [WQ-1:0] op_ff [OPD][WGT_N];

   logic signed [WM-1:0] prod_in [WGT_N];
   logic signed [WM-1:0] prod_ff [WGT_N];
   logic        [WT-1:0] du6_ff, du7_ff;

   logic signed [WS-1:0] sum_p, sum_v, rs_p, rs_v;
   logic signed [WR-1:0] x_in, x_ff, dxdu_in, dxdu_ff;

   logic signed [WV-1:0] pv_in, pv_ff, vr;
   coord_type            pos8_in, pos8_ff, pos9_ff, vel9_in, vel9_ff;

   assign p0 = sx(pt_ff.p0);
   assign p3 = sx(pt_ff.p3);
   assign m0 = sx(pt_ff.m0);
   assign m1 = sx(pt_ff.m1);
   assign dd = p3 - p0;

   assign op_in[0] = p0;
   assign op_in[1] = (p0 <<< 1) + p0 + m0;
   assign op_in[2] = (p3 <<< 1) + p3 - m1;
   assign op_in[3] = p3;
   assign op_in[4] = m0;
   assign op_in[5] = (dd <<< 1) + dd - m0 - m1;
   assign op_in[6] = m1;

   always_comb begin
      for (int j = 0; j < WGT_N; j++) begin
         prod_in[j] = $signed({1'b0, wgt[j]}) * op_ff[OPD-1][j];
      end
   end

   assign sum_p   = prod_ff[0] + prod_ff[1] + prod_ff[2] + prod_ff[3];
   assign sum_v   = prod_ff[4] + prod_ff[5] + prod_ff[6];
   assign rs_p    = (sum_p + HALF_S) >>> FRAC_BITS;
   assign rs_v    = (sum_v + HALF_S) >>> FRAC_BITS;
   assign x_in    = rs_p[WR-1:0];
   assign dxdu_in = rs_v[WR-1:0];

   assign pv_in   = dxdu_ff * $signed({1'b0, du7_ff});
   assign pos8_in = sat({{(WX-WR){x_ff[WR-1]}}, x_ff});
   assign vr      = (pv_ff + HALF_V) >>> FRAC_BITS;
   assign vel9_in = sat(vr[WX-1:0]);

   always_ff @(posedge clock) begin
      if (adv) begin
         pt_ff    <= pt;
         op_ff[0] <= op_in;
         for (int i = 1; i < OPD; i++) begin
            op_ff[i] <= op_ff[i-1];
         end
         prod_ff  <= prod_in;
         du6_ff   <= du;
         du7_ff   <= du6_ff;
         x_ff     <= x_in;
         dxdu_ff  <= dxdu_in;
         pv_ff    <= pv_in;
         pos8_ff  <= pos8_in;
         pos9_ff  <= pos8_ff;
         vel9_ff  <= vel9_in;
      end
   end

   assign res.pos = pos9_ff;
   assign res.vel = vel9_ff;

endmodule

`default_nettype wire

### hdl/sbte_merge.sv
`default_nettype none

module sbte_merge import sbte_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  axis_out_type  res_x,
   input  axis_out_type  res_y,
   output logic          take,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output coord_type     rsp_pos_x,
   output coord_type     rsp_pos_y,
   output coord_type     rsp_vel_x,
   output coord_type     rsp_vel_y
);

   logic      valid_in, valid_ff;
   coord_type pos_x_ff, pos_y_ff, vel_x_ff, vel_y_ff;

   assign take = !valid_ff || rsp_ready;

   always_comb begin
      if (load && take) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && take) begin
         pos_x_ff <= res_x.pos;
         pos_y_ff <= res_y.pos;
         vel_x_ff <= res_x.vel;
         vel_y_ff <= res_y.vel;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_pos_x = pos_x_ff;
   assign rsp_pos_y = pos_y_ff;
   assign rsp_vel_x = vel_x_ff;
   assign rsp_vel_y = vel_y_ff;

endmodule

`default_nettype wire

### sim/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import sbte_pkg::*;

   localparam int FRAC = 16;
   localparam longint ONE = longint'(1) << FRAC;
   localparam longint HALF = longint'(1) << (FRAC - 1);
   localparam coord_type COORD_MAX = 32'sh7fffffff;
   localparam coord_type COORD_MIN = 32'sh80000000;
   localparam int PHASES = 6;
   localparam int RANDOM_PER_PHASE = 108;
   localparam int IDLE_LIMIT = 2000;
   localparam int TAIL_CYCLES = 20;
   localparam int REPORT_MAX = 10;

   typedef struct packed {
      logic signed [PHASE_W-1:0] phase;
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
      coord_type start_tangent_x;
      coord_type start_tangent_y;
      coord_type end_tangent_x;
      coord_type end_tangent_y;
   } swing_request_type;

   typedef struct packed {
      coord_type pos_x;
      coord_type pos_y;
      coord_type vel_x;
      coord_type vel_y;
   } swing_point_type;

   typedef enum {
      PAT_ZERO, PAT_MAX, PAT_MIN, PAT_SPREAD, PAT_SMALL, PAT_WIDE, PAT_FULL
   } coord_pattern_type;

   class trajectory_checker_type;
      logic [EASE_W-1:0] ease = '0;
      swing_point_type pending_points[$];
      int errors = 0;
      int checked = 0;

      function longint round_frac(longint v);
         return (v + HALF) >>> FRAC;
      endfunction

      function coord_type saturate(longint v);
         if (v > 64'sd2147483647) return COORD_MAX;
         if (v < -64'sd2147483648) return COORD_MIN;
         return v[31:0];
      endfunction

      function void eval_axis(input longint p0, p3, m0, m1, b0, b1, b2, b3,
                              c0, c1, c2, du,
                              output coord_type pos, output coord_type vel);
         longint q1, q2, d1, x, dxdu;
         q1 = 3 * p0 + m0;
         q2 = 3 * p3 - m1;
         d1 = 3 * (p3 - p0) - m0 - m1;
         x = round_frac(b0 * p0 + b1 * q1 + b2 * q2 + b3 * p3);
         dxdu = round_frac(c0 * m0 + c1 * d1 + c2 * m1);
         pos = saturate(x);
         vel = saturate(round_frac(dxdu * du));
      endfunction

      function swing_point_type eval_trajectory(swing_request_type r);
         longint t, k, t2, s, u, ds, du, om, om2, u2, b0, b1, b2, b3, c1;
         swing_point_type p;
         t = longint'($signed(r.phase));
         k = longint'(ease);
         if (t < 0) t = 0;
         if (t > ONE) t = ONE;
         if (k > ONE) k = ONE;
         t2 = round_frac(t * t);
         s = round_frac(t2 * (3 * ONE - 2 * t));
         u = round_frac((ONE - k) * t + k * s);
         ds = round_frac(6 * t * (ONE - t));
         du = round_frac((ONE - k) * ONE + k * ds);
         om = ONE - u;
         om2 = round_frac(om * om);
         u2 = round_frac(u * u);
         b0 = round_frac(om2 * om);
         b1 = round_frac(om2 * u);
         b2 = round_frac(om * u2);
         b3 = round_frac(u2 * u);
         c1 = round_frac(2 * om * u);
         eval_axis(longint'(r.start_x), longint'(r.end_x),
                   longint'(r.start_tangent_x), longint'(r.end_tangent_x),
                   b0, b1, b2, b3, om2, c1, u2, du, p.pos_x, p.vel_x);
         eval_axis(longint'(r.start_y), longint'(r.end_y),
                   longint'(r.start_tangent_y), longint'(r.end_tangent_y),
                   b0, b1, b2, b3, om2, c1, u2, du, p.pos_y, p.vel_y);
         return p;
      endfunction

      function void note_request(swing_request_type r);
         pending_points.push_back(eval_trajectory(r));
      endfunction

      function void check_response(swing_point_type got);
         swing_point_type want;
         if (pending_points.size() == 0) begin
            errors++;
            if (errors <= REPORT_MAX)
               $display("response with no request outstanding: pos %0d %0d vel %0d %0d",
                        got.pos_x, got.pos_y, got.vel_x, got.vel_y);
            return;
         end
         want = pending_points.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= REPORT_MAX)
               $display("point %0d: expected pos %0d %0d vel %0d %0d, got pos %0d %0d vel %0d %0d",
                        checked, want.pos_x, want.pos_y, want.vel_x, want.vel_y,
                        got.pos_x, got.pos_y, got.vel_x, got.vel_y);
         end
         checked++;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [EASE_W-1:0] csr_ease_factor = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [PHASE_W-1:0] req_phase = '0;
   coord_type req_start_x = '0;
   coord_type req_start_y = '0;
   coord_type req_end_x = '0;
   coord_type req_end_y = '0;
   coord_type req_start_tangent_x = '0;
   coord_type req_start_tangent_y = '0;
   coord_type req_end_tangent_x = '0;
   coord_type req_end_tangent_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   coord_type rsp_pos_x;
   coord_type rsp_pos_y;
   coord_type rsp_vel_x;
   coord_type rsp_vel_y;

   int send_idle = 0;
   int recv_idle = 0;
   int quiet_cycles = 0;
   trajectory_checker_type traj = new();

   swing_bezier_trajectory_eval u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_ease_factor     (csr_ease_factor),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_phase           (req_phase),
      .req_start_x         (req_start_x),
      .req_start_y         (req_start_y),
      .req_end_x           (req_end_x),
      .req_end_y           (req_end_y),
      .req_start_tangent_x (req_start_tangent_x),
      .req_start_tangent_y (req_start_tangent_y),
      .req_end_tangent_x   (req_end_tangent_x),
      .req_end_tangent_y   (req_end_tangent_y),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pos_x           (rsp_pos_x),
      .rsp_pos_y           (rsp_pos_y),
      .rsp_vel_x           (rsp_vel_x),
      .rsp_vel_y           (rsp_vel_y)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (csr_valid && csr_ready)
            traj.ease = csr_ease_factor;
         if (req_valid && req_ready)
            traj.note_request(swing_request_type'{req_phase, req_start_x, req_start_y,
                                                  req_end_x, req_end_y,
                                                  req_start_tangent_x, req_start_tangent_y,
                                                  req_end_tangent_x, req_end_tangent_y});
         if (rsp_valid && rsp_ready)
            traj.check_response(swing_point_type'{rsp_pos_x, rsp_pos_y,
                                                  rsp_vel_x, rsp_vel_y});
         if ((csr_valid && csr_ready) || (req_valid && req_ready) ||
             (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("swing_bezier_trajectory_eval: mismatch");
            $finish;
         end
      end
   end

   function automatic swing_request_type make_request(int phase, coord_pattern_type pat);
      coord_type c [8];
      swing_request_type r;
      for (int i = 0; i < 8; i++) begin
         case (pat)
            PAT_ZERO:   c[i] = '0;
            PAT_MAX:    c[i] = COORD_MAX;
            PAT_MIN:    c[i] = COORD_MIN;
            PAT_SPREAD: c[i] = (i % 3 == 0) ? COORD_MAX : COORD_MIN;
            PAT_SMALL:  c[i] = $urandom_range(0, 32'h3fffff) - 32'h200000;
            PAT_WIDE:   c[i] = $signed($urandom) >>> $urandom_range(0, 31);
            default:    c[i] = $urandom;
         endcase
      end
      r.phase = phase[PHASE_W-1:0];
      r.start_x = c[0];
      r.start_y = c[1];
      r.end_x = c[2];
      r.end_y = c[3];
      r.start_tangent_x = c[4];
      r.start_tangent_y = c[5];
      r.end_tangent_x = c[6];
      r.end_tangent_y = c[7];
      return r;
   endfunction

   function automatic swing_request_type random_request();
      int sel;
      int phase;
      coord_pattern_type pat;
      sel = $urandom_range(0, 9);
      if (sel == 0)
         phase = $urandom;
      else if (sel == 1)
         phase = $urandom_range(0, 1) ? 0 : int'(ONE);
      else
         phase = $urandom_range(0, int'(ONE));
      sel = $urandom_range(0, 9);
      if (sel < 4)
         pat = PAT_SMALL;
      else if (sel < 7)
         pat = PAT_WIDE;
      else if (sel < 9)
         pat = PAT_FULL;
      else
         pat = coord_pattern_type'($urandom_range(PAT_ZERO, PAT_SPREAD));
      return make_request(phase, pat);
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(input swing_request_type r);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_phase <= r.phase;
      req_start_x <= r.start_x;
      req_start_y <= r.start_y;
      req_end_x <= r.end_x;
      req_end_y <= r.end_y;
      req_start_tangent_x <= r.start_tangent_x;
      req_start_tangent_y <= r.start_tangent_y;
      req_end_tangent_x <= r.end_tangent_x;
      req_end_tangent_y <= r.end_tangent_y;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic write_ease(input logic [EASE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_ease_factor <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_points();
      req_valid <= 1'b0;
      while (traj.pending_points.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic run_directed();
      int dir_phase [12] = '{-131072, -1, 0, 0, 1, 32768, 32768, 65535,
                             65536, 65537, 131071, 21845};
      coord_pattern_type dir_pat [12] = '{PAT_SMALL, PAT_FULL, PAT_MAX, PAT_MIN,
                                          PAT_SMALL, PAT_SPREAD, PAT_MAX, PAT_SMALL,
                                          PAT_MIN, PAT_SPREAD, PAT_ZERO, PAT_WIDE};
      for (int i = 0; i < 12; i++)
         send_request(make_request(dir_phase[i], dir_pat[i]));
   endtask

   initial begin
      logic [EASE_W-1:0] ease_plan [PHASES];
      ease_plan[0] = '0;
      ease_plan[1] = 17'd65536;
      ease_plan[2] = 17'h1ffff;
      ease_plan[3] = 17'd1;
      ease_plan[4] = EASE_W'($urandom);
      ease_plan[5] = EASE_W'($urandom_range(0, 65536));
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < PHASES; ph++) begin
         drain_points();
         case (ph / 2)
            0: begin
               send_idle = 21;
               recv_idle = 72;
            end
            1: begin
               send_idle = 72;
               recv_idle = 21;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
            end
         endcase
         write_ease(ease_plan[ph]);
         if (ph < 2)
            run_directed();
         repeat (RANDOM_PER_PHASE) send_request(random_request());
      end
      drain_points();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (traj.errors == 0)
         $display("swing_bezier_trajectory_eval: match");
      else
         $display("swing_bezier_trajectory_eval: mismatch");
      $finish;
   end

endmodule
